>>> rtl/core/uhpl_pkg.sv
// ----------------------------------------------------------------------------
// uhpl_pkg
// types and constants shared by the url host/port locator
// ----------------------------------------------------------------------------
package uhpl_pkg;

  localparam logic [7:0]  CH_COLON  = 8'h3a;
  localparam logic [7:0]  CH_SLASH  = 8'h2f;
  localparam logic [7:0]  CH_LBRACK = 8'h5b;
  localparam logic [7:0]  CH_RBRACK = 8'h5d;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;

  localparam logic [15:0] DEFAULT_PORT_RST = 16'd80;
  localparam logic [15:0] PORT_MAX         = 16'hffff;
  localparam logic [1:0]  SCHEME_SKIP      = 2'd2;
  localparam logic [7:0]  FIELD8_MAX       = 8'hff;

  typedef enum logic [2:0] {
    PH_SCHEME    = 3'd0,
    PH_SKIP      = 3'd1,
    PH_HOSTSTART = 3'd2,
    PH_IPV4      = 3'd3,
    PH_IPV6      = 3'd4,
    PH_AFTER     = 3'd5,
    PH_DONE      = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNCLOSED = 2'd1,
    ST_SCHEME   = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] url_char;
    logic       is_last;
  } char_item_t;

  typedef struct packed {
    logic [7:0]  host_start;
    logic [7:0]  host_length;
    logic [15:0] port_number;
    logic        port_present;
    logic        host_is_ipv6;
    logic [1:0]  parse_status;
  } result_t;

endpackage

>>> rtl/core/uhpl_stream_if.sv
// ----------------------------------------------------------------------------
// uhpl_stream_if
// valid/ready channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface uhpl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/uhpl_parser.sv
// ----------------------------------------------------------------------------
// uhpl_parser
// per-character phase machine, host span tracking and port accumulator
// ----------------------------------------------------------------------------
module uhpl_parser #(
  parameter int unsigned MAX_URL_LEN = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  uhpl_pkg::char_item_t     item_i,
  input  logic [15:0]              default_port_i,
  output uhpl_pkg::result_t        result_o
);
  import uhpl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_URL_LEN + 1);
  localparam logic [IDX_W-1:0] IDX_LIMIT = IDX_W'(MAX_URL_LEN);

  phase_e           phase_q, phase_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       skip_q, skip_d;
  logic [IDX_W-1:0] begin_q, begin_d;
  logic [IDX_W-1:0] len_q, len_d;
  logic [15:0]      acc_q, acc_d;
  logic             seen_q, seen_d;
  logic             ended_q, ended_d;
  logic             ovf_q, ovf_d;
  logic             v6_q, v6_d;

  logic [7:0]       c;
  logic             is_colon, is_slash, is_digit;
  logic [3:0]       digit;
  logic [19:0]      acc10;
  logic [15:0]      acc_sat;
  logic             in_range;
  logic             v4_act;
  logic             port_act;
  logic [IDX_W-1:0] hb;
  logic [IDX_W-1:0] idx_inc;
  logic             scheme_bad, unclosed, port_hit;

  assign c        = item_i.url_char;
  assign is_colon = (c == CH_COLON);
  assign is_slash = (c == CH_SLASH);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign digit    = 4'(c - CH_ZERO);
  assign acc10    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 20'(digit);
  assign acc_sat  = (acc10 > 20'(PORT_MAX)) ? PORT_MAX : acc10[15:0];
  assign in_range = (idx_q < IDX_LIMIT);
  assign idx_inc  = idx_q + IDX_W'(1);
  assign hb       = (phase_q == PH_HOSTSTART) ? idx_q : begin_q;
  assign v4_act   = (phase_q == PH_IPV4) ||
                    ((phase_q == PH_HOSTSTART) && (c != CH_LBRACK));

  // phase transitions
  always_comb begin
    phase_d = phase_q;
    if (in_range) begin
      unique case (phase_q)
        PH_SCHEME: begin
          if (is_colon) phase_d = PH_SKIP;
        end
        PH_SKIP: begin
          if (skip_q == 2'd1) phase_d = PH_HOSTSTART;
        end
        PH_HOSTSTART: begin
          if (c == CH_LBRACK) phase_d = PH_IPV6;
          else if (is_slash) phase_d = PH_DONE;
          else phase_d = PH_IPV4;
        end
        PH_IPV4: begin
          if (is_slash) phase_d = PH_DONE;
        end
        PH_IPV6: begin
          if (c == CH_RBRACK) phase_d = PH_AFTER;
        end
        PH_AFTER: begin
          if (is_slash) phase_d = PH_DONE;
        end
        PH_DONE: phase_d = PH_DONE;
        default: phase_d = phase_q;
      endcase
    end
  end

  // host span and port datapath
  always_comb begin
    idx_d    = idx_q;
    skip_d   = skip_q;
    begin_d  = begin_q;
    len_d    = len_q;
    v6_d     = v6_q;
    ovf_d    = ovf_q;
    port_act = 1'b0;
    if (!in_range) begin
      ovf_d = 1'b1;
    end else begin
      idx_d = idx_inc;
      if (phase_q == PH_SCHEME && is_colon) skip_d = SCHEME_SKIP;
      if (phase_q == PH_SKIP) begin
        skip_d = skip_q - 2'd1;
        if (skip_q == 2'd1) begin
          begin_d = idx_inc;
          len_d   = '0;
        end
      end
      if (phase_q == PH_HOSTSTART) begin
        if (c == CH_LBRACK) begin
          v6_d    = 1'b1;
          begin_d = idx_inc;
          len_d   = '0;
        end else begin
          begin_d = idx_q;
        end
      end
      if (v4_act) begin
        if (is_slash) begin
          if (!seen_q) len_d = idx_q - hb;
        end else if (is_colon) begin
          len_d    = idx_q - hb;
          port_act = 1'b1;
        end else if (!seen_q) begin
          len_d = idx_inc - hb;
        end else begin
          port_act = 1'b1;
        end
      end
      if (phase_q == PH_IPV6 && c != CH_RBRACK) len_d = idx_inc - begin_q;
      if (phase_q == PH_AFTER && !is_slash) port_act = 1'b1;
    end
  end

  // port digits after the last colon
  always_comb begin
    acc_d   = acc_q;
    seen_d  = seen_q;
    ended_d = ended_q;
    if (port_act) begin
      if (is_colon) begin
        seen_d  = 1'b1;
        acc_d   = '0;
        ended_d = 1'b0;
      end else if (seen_q && !ended_q) begin
        if (is_digit) acc_d = acc_sat;
        else ended_d = 1'b1;
      end
    end
  end

  // result fields from the state after this character
  always_comb begin
    scheme_bad = (phase_d == PH_SCHEME) || (phase_d == PH_SKIP);
    unclosed   = (phase_d == PH_IPV6);
    port_hit   = seen_d && !unclosed;
    if (ovf_d) result_o.parse_status = ST_TOO_LONG;
    else if (scheme_bad) result_o.parse_status = ST_SCHEME;
    else if (unclosed) result_o.parse_status = ST_UNCLOSED;
    else result_o.parse_status = ST_OK;
    if (scheme_bad) begin
      result_o.host_start   = '0;
      result_o.host_length  = '0;
      result_o.port_number  = default_port_i;
      result_o.port_present = 1'b0;
      result_o.host_is_ipv6 = 1'b0;
    end else begin
      result_o.host_start   = (32'(begin_d) > 32'(FIELD8_MAX)) ? FIELD8_MAX : 8'(begin_d);
      result_o.host_length  = (32'(len_d) > 32'(FIELD8_MAX)) ? FIELD8_MAX : 8'(len_d);
      result_o.port_number  = port_hit ? acc_d : default_port_i;
      result_o.port_present = port_hit;
      result_o.host_is_ipv6 = v6_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCHEME;
      idx_q   <= '0;
      skip_q  <= '0;
      begin_q <= '0;
      len_q   <= '0;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      ended_q <= 1'b0;
      ovf_q   <= 1'b0;
      v6_q    <= 1'b0;
    end else if (step_i && item_i.is_last) begin
      phase_q <= PH_SCHEME;
      idx_q   <= '0;
      skip_q  <= '0;
      begin_q <= '0;
      len_q   <= '0;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      ended_q <= 1'b0;
      ovf_q   <= 1'b0;
      v6_q    <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      skip_q  <= skip_d;
      begin_q <= begin_d;
      len_q   <= len_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      ended_q <= ended_d;
      ovf_q   <= ovf_d;
      v6_q    <= v6_d;
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_LIMIT)
    else $error("character index beyond limit");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.is_last |=> phase_q == PH_SCHEME && idx_q == '0 && !ovf_q)
    else $error("state not cleared after last character");
  a_begin_le_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IPV4 || phase_q == PH_IPV6 || phase_q == PH_AFTER) |-> begin_q <= idx_q)
    else $error("host start ahead of character index");
  a_ovf_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> idx_q == IDX_LIMIT)
    else $error("overflow flagged below limit");
`endif

endmodule

>>> rtl/core/url_host_port_locator_top.sv
// One URL character is taken per transfer on char_i, with is_last marking the
// final byte; the block accepts a character every cycle unless a last character
// waits in the input register behind an untaken result, and delivers one result
// on res_o via the input register and then the result register. The rate is
// set by the parser state, updated once per character; a result waiting in the
// result register does not hold off input unless a second last character
// reaches the parser before the first result is taken. default_port is
// written through cfg_i and should only change between URLs.
// ----------------------------------------------------------------------------
// url_host_port_locator_top
// streaming url authority parser returning host span, port and status
// ----------------------------------------------------------------------------
module url_host_port_locator_top #(
  parameter int unsigned MAX_URL_LEN = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  uhpl_stream_if.sink   char_i,
  uhpl_stream_if.source res_o,
  uhpl_stream_if.sink   cfg_i
);
  import uhpl_pkg::*;

  logic        s1_valid_q, s1_valid_d;
  char_item_t  s1_item_q;
  logic        out_valid_q, out_valid_d;
  result_t     out_data_q;
  logic [15:0] default_port_q;
  result_t     result;
  logic        out_free;
  logic        s1_adv;
  logic        in_xfer;

  assign out_free     = !out_valid_q || res_o.ready;
  assign s1_adv       = s1_valid_q && (!s1_item_q.is_last || out_free);
  assign char_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer      = char_i.valid && char_i.ready;
  assign cfg_i.ready  = 1'b1;
  assign res_o.valid  = out_valid_q;
  assign res_o.data   = out_data_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_xfer) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_item_q.is_last) out_valid_d = 1'b1;
    else if (res_o.ready) out_valid_d = 1'b0;
  end

  uhpl_parser #(
    .MAX_URL_LEN(MAX_URL_LEN)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (s1_adv),
    .item_i        (s1_item_q),
    .default_port_i(default_port_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      default_port_q <= DEFAULT_PORT_RST;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) default_port_q <= cfg_i.data;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) s1_item_q <= char_i.data;
    if (s1_adv && s1_item_q.is_last) out_data_q <= result;
  end

`ifndef SYNTHESIS
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_item_q))
    else $error("input register lost a stalled character");
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_item_q.is_last))
    else $error("result appeared without a last character");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_item_q.is_last |=> out_valid_q)
    else $error("last character produced no result");
`endif

endmodule
